@@ rtl/lshm_pkg.sv @@
// Package with the item types, register indexes, reset values and control types of the monitor.
`default_nettype none

package lshm_pkg;

    localparam int unsigned MAX_BUCKETS_DEF = 256;
    localparam int LAT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int BKT_CFG_W = 9;
    localparam int BUCKET_OUT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_EN = 2'd2;

    localparam logic [LAT_W-1:0] RESET_DEADLINE = 32'd1000;
    localparam logic [BKT_CFG_W-1:0] RESET_BUCKETS = 9'd100;

    typedef struct packed {
        logic             cmd;
        logic [LAT_W-1:0] lat_sample;
    } t_in_item;

    typedef struct packed {
        logic                    deadline_missed;
        logic [BUCKET_OUT_W-1:0] bucket;
        logic [31:0]             bucket_total;
        logic [63:0]             sample_count;
        logic [63:0]             miss_count;
        logic [LAT_W-1:0]        lowest_lat;
        logic [LAT_W-1:0]        highest_lat;
        logic [63:0]             latency_sum;
        logic [63:0]             latency_square_sum;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic sweep;
        logic mul;
        logic acc;
        logic div_step;
        logic write;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic item_clear;
        logic hist_en;
        logic to_last;
        logic sweep_last;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/lshm_ctrl.sv @@
// Controller state machine that sequences clears, statistics updates, division and histogram access.
`default_nettype none

module lshm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lshm_pkg::t_dp_status i_status,
    output lshm_pkg::t_dp_cmd        o_cmd
);
    import lshm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = i_status.item_clear ? ST_CLEAR : ST_MUL;
            end
            ST_CLEAR: begin
                if (i_status.sweep_last) n_state = ST_DONE;
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: begin
                if (!i_status.hist_en) n_state = ST_DONE;
                else if (i_status.to_last) n_state = ST_READ;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_READ;
            end
            ST_READ: n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: o_cmd.sweep = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_CLEAR: o_cmd.sweep = 1'b1;
            ST_MUL: o_cmd.mul = 1'b1;
            ST_ACC: o_cmd.acc = 1'b1;
            ST_DIV: o_cmd.div_step = 1'b1;
            ST_READ: o_cmd = '0;
            ST_WRITE: o_cmd.write = 1'b1;
            ST_DONE: o_cmd.load_out = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lshm_dp.sv @@
// Datapath with configuration, statistics registers, serial divider, histogram memory and output register.
`default_nettype none

module lshm_dp #(
    parameter int unsigned MAX_BUCKETS = lshm_pkg::MAX_BUCKETS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lshm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lshm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire lshm_pkg::t_in_item                i_in_item,
    output lshm_pkg::t_out_item                    o_out_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire lshm_pkg::t_dp_cmd                 i_cmd,
    output lshm_pkg::t_dp_status                   o_status
);
    import lshm_pkg::*;

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int PW = LAT_W + BW;
    localparam logic [BW-1:0] LastIdx = BW'(MAX_BUCKETS - 1);
    localparam logic [BW-1:0] LastStep = BW'(BW - 1);

    logic [LAT_W-1:0]     r_deadline;
    logic [BKT_CFG_W-1:0] r_buckets;
    logic                 r_hist_en;

    logic [LAT_W-1:0] r_lat;
    logic [63:0]      r_count;
    logic [63:0]      r_misses;
    logic [LAT_W-1:0] r_min;
    logic [LAT_W-1:0] r_max;
    logic [63:0]      r_sum;
    logic [63:0]      r_sqsum;
    logic             r_last_miss;

    logic [PW-1:0]    r_prod;
    logic [63:0]      r_sq;
    logic [LAT_W-1:0] r_rem;
    logic [BW-1:0]    r_quo;
    logic [BW-1:0]    r_cnt;
    logic [BW-1:0]    r_bucket;
    logic [31:0]      r_total;
    logic [31:0]      r_rd;
    logic [31:0]      r_mem [MAX_BUCKETS];

    logic      r_out_valid;
    t_out_item r_out;

    logic [BW-1:0]    nm1;
    logic [64:0]      n_sum_w;
    logic [64:0]      n_sq_w;
    logic [63:0]      n_sum;
    logic [63:0]      n_sqsum;
    logic [63:0]      n_count;
    logic [63:0]      n_misses;
    logic             n_miss;
    logic [LAT_W:0]   n_trial;
    logic             n_fit;
    logic [LAT_W-1:0] n_rem;
    logic [BW-1:0]    n_quo;
    logic [31:0]      n_total;

    always_comb begin
        if (32'(r_buckets) < 32'd2) begin
            nm1 = BW'(1);
        end else if (32'(r_buckets) > MAX_BUCKETS) begin
            nm1 = LastIdx;
        end else begin
            nm1 = BW'(r_buckets - 9'd1);
        end
    end

    always_comb begin
        n_sum_w = {1'b0, r_sum} + 65'(r_lat);
        n_sum = n_sum_w[64] ? '1 : n_sum_w[63:0];
        n_sq_w = {1'b0, r_sqsum} + {1'b0, r_sq};
        n_sqsum = n_sq_w[64] ? '1 : n_sq_w[63:0];
        n_count = (r_count == '1) ? r_count : r_count + 64'd1;
        n_misses = (r_misses == '1) ? r_misses : r_misses + 64'd1;
        n_miss = r_lat > r_deadline;
        n_trial = {r_rem, r_quo[BW-1]};
        n_fit = n_trial >= {1'b0, r_deadline};
        n_rem = n_fit ? LAT_W'(n_trial - {1'b0, r_deadline}) : n_trial[LAT_W-1:0];
        n_quo = BW'({r_quo, n_fit});
        n_total = (r_rd == '1) ? r_rd : r_rd + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= RESET_DEADLINE;
            r_buckets <= RESET_BUCKETS;
            r_hist_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEADLINE: r_deadline <= i_cfg_data;
                CFG_BUCKETS: r_buckets <= i_cfg_data[BKT_CFG_W-1:0];
                CFG_HIST_EN: r_hist_en <= i_cfg_data[0];
                default: r_hist_en <= r_hist_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_misses <= '0;
            r_min <= '1;
            r_max <= '0;
            r_sum <= '0;
            r_sqsum <= '0;
            r_last_miss <= 1'b0;
        end else if (i_cmd.accept && i_in_item.cmd) begin
            r_count <= '0;
            r_misses <= '0;
            r_min <= '1;
            r_max <= '0;
            r_sum <= '0;
            r_sqsum <= '0;
            r_last_miss <= 1'b0;
        end else if (i_cmd.mul) begin
            r_count <= n_count;
            if (r_lat < r_min) r_min <= r_lat;
            if (r_lat > r_max) r_max <= r_lat;
            r_sum <= n_sum;
            r_last_miss <= n_miss;
            if (n_miss) r_misses <= n_misses;
        end else if (i_cmd.acc) begin
            r_sqsum <= n_sqsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept || i_cmd.acc) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt <= (r_cnt == LastIdx) ? '0 : r_cnt + BW'(1);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lat <= i_in_item.lat_sample;
            r_bucket <= '0;
            r_total <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_lat) * PW'(nm1);
            r_sq <= 64'(r_lat) * 64'(r_lat);
        end
        if (i_cmd.acc) begin
            if (r_hist_en && r_lat >= r_deadline) begin
                r_bucket <= nm1;
            end
            r_rem <= r_prod[PW-1:BW];
            r_quo <= r_prod[BW-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_bucket <= n_quo;
        end
        if (i_cmd.write) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[r_cnt] <= '0;
        end else if (i_cmd.write) begin
            r_mem[r_bucket] <= n_total;
        end
        r_rd <= r_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.deadline_missed <= r_last_miss;
            r_out.bucket <= BUCKET_OUT_W'(r_bucket);
            r_out.bucket_total <= r_total;
            r_out.sample_count <= r_count;
            r_out.miss_count <= r_misses;
            r_out.lowest_lat <= r_min;
            r_out.highest_lat <= r_max;
            r_out.latency_sum <= r_sum;
            r_out.latency_square_sum <= r_sqsum;
        end
    end

    always_comb begin
        o_status.item_clear = i_in_item.cmd;
        o_status.hist_en = r_hist_en;
        o_status.to_last = r_lat >= r_deadline;
        o_status.sweep_last = r_cnt == LastIdx;
        o_status.div_last = r_cnt == LastStep;
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_item = r_out;
    assign o_out_valid = r_out_valid;

    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> r_bucket <= nm1)
        else $error("histogram write beyond the last bucket in use");

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_valid || i_out_ready)
        else $error("output register overwritten before its item was taken");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_min <= r_max)
        else $error("minimum latency above maximum latency");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_deadline)
        else $error("division remainder not below the deadline");

endmodule

`default_nettype wire

@@ rtl/latency_stats_histogram_monitor_top.sv @@
// Top level of the latency statistics and histogram monitor.
`default_nettype none

// Each item is either a latency sample or a clear command and yields exactly one result item
// with the statistics after that command. A sample passes through the multiply and accumulate
// steps, the serial divider, which retires one quotient bit per cycle (8 divider steps for the
// default of 256 buckets), and the histogram read and write; samples at or above the deadline
// skip the divider, and with the histogram disabled a sample goes from the accumulate step
// straight to the result. The next item is accepted in the cycle after the result is loaded.
// A clear command, and the pass that follows reset, sweep the histogram memory one entry per cycle; no item
// is accepted during the pass after reset, while configuration writes are taken at any time.
// The result sits in an output register, so the block takes the next item while an earlier
// result waits.
module latency_stats_histogram_monitor_top #(
    parameter int unsigned MAX_BUCKETS = lshm_pkg::MAX_BUCKETS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lshm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lshm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire lshm_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output lshm_pkg::t_out_item                  o_out_item
);
    import lshm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    lshm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lshm_dp #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire
